// ===== hw/rtl/dbs_pkg.sv =====
package dbs_pkg;

    localparam int unsigned DefLevels = 10;
    localparam int unsigned KeyW      = 32;
    localparam int unsigned LevelW    = 4;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_SEARCH = 1'b1
    } kind_t;

    typedef struct packed {
        logic start_search;
        logic start_merge;
        logic start_insert0;
        logic done_ack;
    } dbs_cmd_t;

    typedef struct packed {
        logic busy;
        logic finish;
        logic found;
    } dbs_status_t;

endpackage

// ===== hw/rtl/dbs_datapath.sv =====
module dbs_datapath #(
    parameter int unsigned LEVELS = dbs_pkg::DefLevels,
    parameter int unsigned LW     = $clog2(LEVELS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dbs_pkg::dbs_cmd_t        cmd,
    input  logic [dbs_pkg::KeyW-1:0] key_in,
    input  logic [LEVELS-1:0]        count,
    input  logic [LW-1:0]            dst_level,
    output dbs_pkg::dbs_status_t     status,
    output logic [LW-1:0]            hit_level
);
    import dbs_pkg::*;

    localparam int unsigned SD = (1 << LEVELS) - 1;
    localparam int unsigned CD = 1 << (LEVELS - 1);
    localparam int unsigned AW = LEVELS;
    localparam int unsigned CW = (LEVELS > 1) ? LEVELS - 1 : 1;

    typedef enum logic [9:0] {
        D_IDLE  = 10'b0000000001,
        D_SNEXT = 10'b0000000010,
        D_SRD   = 10'b0000000100,
        D_SCMP  = 10'b0000001000,
        D_MINIT = 10'b0000010000,
        D_MRD   = 10'b0000100000,
        D_MCMP  = 10'b0001000000,
        D_CRD   = 10'b0010000000,
        D_CWR   = 10'b0100000000,
        D_DONE  = 10'b1000000000
    } dp_state_t;

    dp_state_t state_reg, state_next;

    logic [KeyW-1:0] store_mem [SD];
    logic [KeyW-1:0] scr_mem [CD];
    logic [KeyW-1:0] st_rd_reg, sc_rd_reg;
    logic [AW-1:0]   st_raddr, st_waddr;
    logic [CW-1:0]   sc_raddr, sc_waddr;
    logic            st_we, sc_we;
    logic [KeyW-1:0] st_wdata, sc_wdata;

    logic [KeyW-1:0] k_reg;
    logic [LW-1:0]   lvl_reg, lvl_next;
    logic [AW:0]     lo_reg, lo_next, hi_reg, hi_next, mid;
    logic [AW:0]     l_reg, l_next, r_reg, r_next, o_reg, o_next, m_reg, m_next;
    logic            found_reg, found_next;
    logic [AW-1:0]   base, dbase;

    assign base  = AW'((1 << lvl_reg) - 1);
    assign dbase = AW'((1 << dst_level) - 1);
    assign mid   = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= st_wdata;
        end
        st_rd_reg <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sc_we)
        begin
            scr_mem[sc_waddr] <= sc_wdata;
        end
        sc_rd_reg <= scr_mem[sc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_search || cmd.start_merge || cmd.start_insert0)
        begin
            k_reg <= key_in ^ {1'b1, {(KeyW-1){1'b0}}};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        lvl_next   = lvl_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        l_next     = l_reg;
        r_next     = r_reg;
        o_next     = o_reg;
        m_next     = m_reg;
        found_next = found_reg;
        st_we      = 1'b0;
        sc_we      = 1'b0;
        st_waddr   = '0;
        sc_waddr   = '0;
        st_wdata   = '0;
        sc_wdata   = '0;
        st_raddr   = '0;
        sc_raddr   = '0;
        unique case (state_reg)
            D_IDLE:
            begin
                if (cmd.start_search)
                begin
                    lvl_next   = '0;
                    found_next = 1'b0;
                    state_next = D_SNEXT;
                end
                else if (cmd.start_insert0)
                begin
                    st_we      = 1'b1;
                    st_waddr   = '0;
                    st_wdata   = key_in ^ {1'b1, {(KeyW-1){1'b0}}};
                    state_next = D_DONE;
                end
                else if (cmd.start_merge)
                begin
                    sc_we      = 1'b1;
                    sc_waddr   = '0;
                    sc_wdata   = key_in ^ {1'b1, {(KeyW-1){1'b0}}};
                    lvl_next   = '0;
                    m_next     = (AW+1)'(1);
                    state_next = D_MINIT;
                end
            end
            D_SNEXT:
            begin
                if (lvl_reg >= LW'(LEVELS))
                begin
                    state_next = D_DONE;
                end
                else if (count[lvl_reg[$clog2(LEVELS)-1:0]])
                begin
                    lo_next    = '0;
                    hi_next    = (AW+1)'(1) << lvl_reg;
                    state_next = D_SRD;
                end
                else
                begin
                    lvl_next = lvl_reg + LW'(1);
                end
            end
            D_SRD:
            begin
                if (lo_reg < hi_reg)
                begin
                    st_raddr   = base + mid[AW-1:0];
                    state_next = D_SCMP;
                end
                else
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = D_SNEXT;
                end
            end
            D_SCMP:
            begin
                if (st_rd_reg == k_reg)
                begin
                    found_next = 1'b1;
                    state_next = D_DONE;
                end
                else
                begin
                    if (st_rd_reg < k_reg)
                    begin
                        lo_next = mid + (AW+1)'(1);
                    end
                    else
                    begin
                        hi_next = mid;
                    end
                    state_next = D_SRD;
                end
            end
            D_MINIT:
            begin
                l_next     = '0;
                r_next     = '0;
                o_next     = '0;
                state_next = D_MRD;
            end
            D_MRD:
            begin
                if (o_reg == (m_reg << 1))
                begin
                    m_next = m_reg << 1;
                    if (lvl_reg + LW'(1) < dst_level)
                    begin
                        o_next     = '0;
                        state_next = D_CRD;
                    end
                    else
                    begin
                        state_next = D_DONE;
                    end
                end
                else
                begin
                    st_raddr   = base + l_reg[AW-1:0];
                    sc_raddr   = r_reg[CW-1:0];
                    state_next = D_MCMP;
                end
            end
            D_MCMP:
            begin
                st_we    = 1'b1;
                st_waddr = dbase + o_reg[AW-1:0];
                if ((l_reg < m_reg) &&
                    ((r_reg >= m_reg) || (st_rd_reg <= sc_rd_reg)))
                begin
                    st_wdata = st_rd_reg;
                    l_next   = l_reg + (AW+1)'(1);
                end
                else
                begin
                    st_wdata = sc_rd_reg;
                    r_next   = r_reg + (AW+1)'(1);
                end
                o_next     = o_reg + (AW+1)'(1);
                state_next = D_MRD;
            end
            D_CRD:
            begin
                if (o_reg == m_reg)
                begin
                    lvl_next   = lvl_reg + LW'(1);
                    state_next = D_MINIT;
                end
                else
                begin
                    st_raddr   = dbase + o_reg[AW-1:0];
                    state_next = D_CWR;
                end
            end
            D_CWR:
            begin
                sc_we      = 1'b1;
                sc_waddr   = o_reg[CW-1:0];
                sc_wdata   = st_rd_reg;
                o_next     = o_reg + (AW+1)'(1);
                state_next = D_CRD;
            end
            D_DONE:
            begin
                if (cmd.done_ack)
                begin
                    state_next = D_IDLE;
                end
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            found_reg <= 1'b0;
            lvl_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            lvl_reg   <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        l_reg  <= l_next;
        r_reg  <= r_next;
        o_reg  <= o_next;
        m_reg  <= m_next;
    end

    assign status.busy   = (state_reg != D_IDLE);
    assign status.finish = (state_reg == D_DONE);
    assign status.found  = found_reg;
    assign hit_level     = lvl_reg;

    a_done_ack: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.done_ack |-> state_reg == D_DONE)
        else $error("ack outside done");
    a_merge_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == D_MCMP |-> (l_reg < m_reg) || (r_reg < m_reg))
        else $error("merge overrun");
    a_search_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == D_DONE && found_reg) |-> lvl_reg < LW'(LEVELS))
        else $error("bad hit level");

endmodule

// ===== hw/rtl/dbs_ctrl.sv =====
module dbs_ctrl #(
    parameter int unsigned LEVELS = dbs_pkg::DefLevels,
    parameter int unsigned LW     = $clog2(LEVELS + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic [dbs_pkg::LevelW-1:0] level,
    output logic                       full_res,
    output dbs_pkg::dbs_cmd_t          cmd,
    input  dbs_pkg::dbs_status_t       status,
    input  logic [LW-1:0]              hit_level,
    output logic [LEVELS-1:0]          count,
    output logic [LW-1:0]              dst_level
);
    import dbs_pkg::*;

    typedef enum logic [2:0] {
        C_IDLE = 3'b001,
        C_WORK = 3'b010,
        C_OUT  = 3'b100
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [LEVELS-1:0] count_reg, count_next;
    logic              found_reg, found_next, full_reg, full_next;
    logic [LevelW-1:0] level_reg, level_next;
    logic              is_ins, is_full, accept;
    logic              ins_reg;
    logic [LW-1:0]     j;

    assign count   = count_reg;
    assign is_ins  = (kind_t'(kind) == KIND_INSERT);
    assign is_full = &count_reg;
    assign accept  = in_valid && in_ready;

    always_comb
    begin
        j = LW'(LEVELS);
        for (int i = LEVELS - 1; i >= 0; i--)
        begin
            if (!count_reg[i])
            begin
                j = LW'(i);
            end
        end
    end
    assign dst_level = j;

    assign in_ready  = (state_reg == C_IDLE);
    assign out_valid = (state_reg == C_OUT);
    assign found     = found_reg;
    assign level     = level_reg;
    assign full_res  = full_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        found_next = found_reg;
        full_next  = full_reg;
        level_next = level_reg;
        cmd        = '0;
        unique case (state_reg)
            C_IDLE:
            begin
                if (accept)
                begin
                    found_next = 1'b0;
                    level_next = '0;
                    full_next  = 1'b0;
                    if (is_ins && is_full)
                    begin
                        full_next  = 1'b1;
                        state_next = C_OUT;
                    end
                    else if (is_ins)
                    begin
                        cmd.start_insert0 = (j == '0);
                        cmd.start_merge   = (j != '0);
                        state_next        = C_WORK;
                    end
                    else
                    begin
                        cmd.start_search = 1'b1;
                        state_next       = C_WORK;
                    end
                end
            end
            C_WORK:
            begin
                if (status.finish)
                begin
                    cmd.done_ack = 1'b1;
                    if (!ins_reg)
                    begin
                        found_next = status.found;
                        level_next = status.found ? LevelW'(hit_level) : '0;
                    end
                    else
                    begin
                        count_next = count_reg + LEVELS'(1);
                    end
                    state_next = C_OUT;
                end
            end
            C_OUT:
            begin
                if (out_ready)
                begin
                    state_next = C_IDLE;
                end
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        full_reg  <= full_next;
        level_reg <= level_next;
        if (accept)
        begin
            ins_reg <= is_ins;
        end
    end

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && full_res) |-> is_full)
        else $error("full flag without full store");
    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(full_res && found))
        else $error("full and found together");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == C_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("count moved while idle");

endmodule

// ===== hw/rtl/dynamic_binary_search.sv =====
// search: binary search of each occupied level in turn, from level 0 up, stopping at the first hit
// insert into level j (the lowest empty level): merges the key with levels 0 to j-1 through scratch copies
// a single merge/search engine serves both operations over one store memory
// one word in flight; the next is accepted after the result is taken
// rst_n clears the element count and control; store contents stay undefined
module dynamic_binary_search #(
    parameter int unsigned LEVELS = dbs_pkg::DefLevels
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       kind,
    input  logic signed [31:0]         key,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       found,
    output logic [dbs_pkg::LevelW-1:0] level,
    output logic                       full_res
);
    import dbs_pkg::*;

    localparam int unsigned LW = $clog2(LEVELS + 1);

    dbs_cmd_t          cmd;
    dbs_status_t       status;
    logic [LW-1:0]     hit_level, dst_level;
    logic [LEVELS-1:0] count;
    logic [KeyW-1:0]   key_q;

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            key_q <= key;
        end
    end

    dbs_ctrl #(.LEVELS(LEVELS), .LW(LW)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .out_valid(out_valid), .out_ready(out_ready),
        .found(found), .level(level), .full_res(full_res),
        .cmd(cmd), .status(status), .hit_level(hit_level),
        .count(count), .dst_level(dst_level)
    );

    dbs_datapath #(.LEVELS(LEVELS), .LW(LW)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .key_in((cmd.start_search || cmd.start_merge || cmd.start_insert0) ? key : key_q),
        .count(count), .dst_level(dst_level),
        .status(status), .hit_level(hit_level)
    );

endmodule

// ===== tb/sv/dbs_checker.sv =====
module dbs_checker #(
    parameter int unsigned LEVELS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       kind,
    input  logic signed [31:0]         key,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       found,
    input  logic [dbs_pkg::LevelW-1:0] level,
    input  logic                       full_res,
    output int                         errors,
    output int                         pending
);
    import dbs_pkg::*;

    localparam int unsigned Capacity = (1 << LEVELS) - 1;

    typedef struct packed {
        logic                found;
        logic [LevelW-1:0]   level;
        logic                full_res;
    } answer_t;

    // each level kept as a sorted list of keys
    logic signed [31:0] sorted_levels[LEVELS][$];
    int unsigned        key_count;
    answer_t            answers_due[$];

    function automatic answer_t predict_answer(kind_t op, logic signed [31:0] k);
        answer_t            a;
        int unsigned        j;
        logic signed [31:0] merged[$];
        logic signed [31:0] lower[$];
        logic signed [31:0] upper[$];
        a = '0;
        if (op == KIND_INSERT) begin
            if (key_count >= Capacity) begin
                a.full_res = 1'b1;
            end
            else begin
                j = 0;
                while (key_count[j]) begin
                    j++;
                end
                merged = {k};
                for (int i = 0; i < j; i++) begin
                    lower = sorted_levels[i];
                    upper = merged;
                    merged = {};
                    while (lower.size() > 0 || upper.size() > 0) begin
                        if (upper.size() == 0 ||
                            (lower.size() > 0 && lower[0] <= upper[0])) begin
                            merged.push_back(lower.pop_front());
                        end
                        else begin
                            merged.push_back(upper.pop_front());
                        end
                    end
                    sorted_levels[i] = {};
                end
                sorted_levels[j] = merged;
                key_count++;
            end
        end
        else begin
            for (int i = 0; i < LEVELS; i++) begin
                if (key_count[i] && !a.found) begin
                    foreach (sorted_levels[i][n]) begin
                        if (sorted_levels[i][n] == k) begin
                            a.found = 1'b1;
                        end
                    end
                    if (a.found) begin
                        a.level = LevelW'(i);
                    end
                end
            end
        end
        return a;
    endfunction

    assign pending = answers_due.size();

    always @(posedge clk or negedge rst_n) begin
        answer_t want;
        if (!rst_n) begin
            key_count <= 0;
            errors    <= 0;
            answers_due.delete();
            for (int i = 0; i < LEVELS; i++) begin
                sorted_levels[i] = {};
            end
        end
        else begin
            if (in_valid && in_ready) begin
                answers_due.push_back(predict_answer(kind_t'(kind), key));
            end
            if (out_valid && out_ready) begin
                if (answers_due.size() == 0) begin
                    if (errors < 10) begin
                        $display("unexpected word: found=%0d level=%0d full=%0d",
                                 found, level, full_res);
                    end
                    errors <= errors + 1;
                end
                else begin
                    want = answers_due.pop_front();
                    if (want.found !== found || want.level !== level ||
                        want.full_res !== full_res) begin
                        if (errors < 10) begin
                            $display("mismatch: expected found=%0d level=%0d full=%0d, got found=%0d level=%0d full=%0d",
                                     want.found, want.level, want.full_res,
                                     found, level, full_res);
                        end
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== tb/sv/tb_dynamic_binary_search.sv =====
module tb_dynamic_binary_search;
    import dbs_pkg::*;

    localparam int unsigned Capacity  = (1 << DefLevels) - 1;
    localparam int          CycleCap  = 1500000;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                kind = 1'b0;
    logic signed [31:0]  key = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                found;
    logic [LevelW-1:0]   level;
    logic                full_res;
    int                  errors;
    int                  pending;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_off = 0;
    int                  cycles = 0;
    int unsigned         inserted = 0;
    logic signed [31:0]  stored_keys[$];

    always #6 clk = ~clk;

    dynamic_binary_search dut (.*);

    dbs_checker #(.LEVELS(DefLevels)) u_checker (.*);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleCap)
        begin
            $display("dynamic_binary_search regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // called and returns at a falling edge; valid stays high into the next word
    task automatic send_word(kind_t op, logic signed [31:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        while (!in_ready)
        begin
            @(negedge clk);
        end
        @(negedge clk);
        if (op == KIND_INSERT && inserted < Capacity)
        begin
            inserted++;
            stored_keys.push_back(k);
        end
    endtask

    function automatic logic signed [31:0] pick_key();
        if (stored_keys.size() > 0 && $urandom_range(1))
        begin
            return stored_keys[$urandom_range(stored_keys.size() - 1)];
        end
        return $urandom_range(3) == 0 ? $urandom() : $urandom_range(40) - 20;
    endfunction

    initial
    begin
        logic signed [31:0] edges[6];
        edges = '{32'sh8000_0000, 32'sh7fff_ffff, 0, -1, 1, 32'sh5555_aaaa};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_word(KIND_SEARCH, 0);
        foreach (edges[i])
        begin
            send_word(KIND_INSERT, edges[i]);
            send_word(KIND_SEARCH, edges[i]);
        end
        send_word(KIND_INSERT, 32'sh7fff_ffff);
        send_word(KIND_SEARCH, 32'sh7fff_ffff);
        send_word(KIND_SEARCH, 32'sh1234_5678);
        send_word(KIND_SEARCH, ~32'sh5555_aaaa);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = phase == 0 ? 15 : (phase == 1 ? 49 : 0);
            recv_idle_pct = phase == 0 ? 49 : (phase == 1 ? 15 : 0);
            if (phase == 2)
            begin
                hold_off = 400;
            end
            for (int n = 0; n < 165; n++)
            begin
                send_word(kind_t'($urandom_range(1)), pick_key());
            end
        end
        send_idle_pct = 0;
        repeat (4) send_word(KIND_INSERT, $urandom());
        for (int n = 0; n < 40; n++)
        begin
            send_word(KIND_SEARCH, pick_key());
        end
        in_valid <= 1'b0;
        while (pending > 0)
        begin
            @(posedge clk);
        end
        repeat (300) @(posedge clk);
        if (errors == 0)
        begin
            $display("dynamic_binary_search regression: pass");
        end
        else
        begin
            $display("dynamic_binary_search regression: fail");
        end
        $finish;
    end
endmodule

// ===== dynamic_binary_search.f =====
hw/rtl/dbs_pkg.sv
hw/rtl/dbs_datapath.sv
hw/rtl/dbs_ctrl.sv
hw/rtl/dynamic_binary_search.sv
tb/sv/dbs_checker.sv
tb/sv/tb_dynamic_binary_search.sv
